FILE: rtl/fre_pkg.sv
// fre_pkg: shared types and constants of the frame rotation engine.
// No dependencies; every rtl/ file refers to it by scoped names.
`default_nettype none

package fre_pkg;

  localparam int PIX_W     = 24;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [CFG_W-1:0]     size_t;
  typedef logic [PIX_W-1:0]     pix_t;

  // Configuration register indexes
  localparam cfg_idx_t CFG_FRAME_WIDTH   = 2'd0;
  localparam cfg_idx_t CFG_FRAME_HEIGHT  = 2'd1;
  localparam cfg_idx_t CFG_ROTATION_MODE = 2'd2;

  // Item opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  // Rotation modes
  localparam logic MODE_QUARTER = 1'b0;
  localparam logic MODE_HALF    = 1'b1;

  typedef struct packed {
    logic op;
    pix_t pixel;
  } in_item_t;

  typedef struct packed {
    pix_t pixel_out;
    logic last_pixel;
    logic error;
  } out_item_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } fre_state_t;

  // Controller to datapath
  typedef struct packed {
    logic wr;
    logic rd;
    logic err;
    logic clr;
  } fre_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic load_last;
    logic frame_last;
  } fre_status_t;

endpackage

`default_nettype wire

FILE: rtl/frame_rotation_engine.sv
// frame_rotation_engine: top level, configuration registers and size clamp.
// Depends on fre_pkg, fre_ctrl and fre_datapath.
//
// The engine takes one item per clock and never raises busy: a write item
// stores the next pixel of the frame in row-major order, a fetch item returns
// the next pixel of the rotated frame (quarter or half turn) in the cycle after
// it is accepted, with out_strobe high for that single cycle. The result
// comes from the registered read port of the single-port-per-direction frame
// store. The receiver cannot stall: every strobed result must be captured
// in the cycle it appears. Writes to a frame that is already complete are
// dropped; a fetch before the frame is complete returns a zero pixel with
// error set. The fetch that delivers last_pixel rearms the engine for the
// next frame. Any write to a defined configuration register also rearms it;
// sizes of zero act as one and sizes above the store's maximum act as that
// maximum. No clearing pass runs after reset.
`default_nettype none

module frame_rotation_engine #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  wire                    clk,
  input  wire                    rst_n,
  // item channel
  input  wire                    start,
  output logic                   busy,
  input  fre_pkg::in_item_t      in_item,
  // result channel
  output logic                   out_strobe,
  output fre_pkg::out_item_t     out_item,
  // configuration port
  input  wire                    cfg_we,
  input  fre_pkg::cfg_idx_t      cfg_index,
  input  fre_pkg::size_t         cfg_data
);

  // Largest size a 7-bit register can ask for that the store still holds
  localparam fre_pkg::size_t W_MAX = (MAX_WIDTH  > 127) ? 7'd127 : 7'(MAX_WIDTH);
  localparam fre_pkg::size_t H_MAX = (MAX_HEIGHT > 127) ? 7'd127 : 7'(MAX_HEIGHT);

  fre_pkg::size_t       frame_width_r;
  fre_pkg::size_t       frame_height_r;
  logic                 rotation_mode_r;

  logic                 restart;
  fre_pkg::size_t       eff_w;
  fre_pkg::size_t       eff_h;
  fre_pkg::fre_cmd_t    cmd;
  fre_pkg::fre_status_t status;

  // Decode config writes; an undefined index changes nothing
  always_comb begin
    restart = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        fre_pkg::CFG_FRAME_WIDTH,
        fre_pkg::CFG_FRAME_HEIGHT,
        fre_pkg::CFG_ROTATION_MODE: restart = 1'b1;
        default:                    restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r   <= 7'd64;
      frame_height_r  <= 7'd64;
      rotation_mode_r <= fre_pkg::MODE_QUARTER;
    end else if (cfg_we) begin
      case (cfg_index)
        fre_pkg::CFG_FRAME_WIDTH:   frame_width_r   <= cfg_data;
        fre_pkg::CFG_FRAME_HEIGHT:  frame_height_r  <= cfg_data;
        fre_pkg::CFG_ROTATION_MODE: rotation_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Clamp sizes into 1..max
  assign eff_w = (frame_width_r == '0) ? 7'd1 :
                 (frame_width_r > W_MAX) ? W_MAX : frame_width_r;
  assign eff_h = (frame_height_r == '0) ? 7'd1 :
                 (frame_height_r > H_MAX) ? H_MAX : frame_height_r;

  // Every item is taken in the cycle it arrives, so the engine is never busy
  assign busy = 1'b0;

  fre_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start && !busy),
    .op      (in_item.op),
    .restart (restart),
    .status  (status),
    .cmd     (cmd)
  );

  fre_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .frame_w    (eff_w),
    .frame_h    (eff_h),
    .mode       (rotation_mode_r),
    .wr_pixel   (in_item.pixel),
    .status     (status),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

`default_nettype wire

FILE: rtl/fre_store.sv
// fre_store: frame store, one write port and one registered read port.
// Depends on fre_pkg for the pixel type.
`default_nettype none

module fre_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire              clk,
  input  wire              we,
  input  wire [AW-1:0]     waddr,
  input  fre_pkg::pix_t    wdata,
  input  wire              re,
  input  wire [AW-1:0]     raddr,
  output fre_pkg::pix_t    rdata
);

  fre_pkg::pix_t mem [DEPTH];
  fre_pkg::pix_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: rtl/fre_ctrl.sv
// fre_ctrl: load/drain controller of the frame rotation engine.
// Depends on fre_pkg for state, command and status types.
`default_nettype none

module fre_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  input  wire                 op,
  input  wire                 restart,
  input  fre_pkg::fre_status_t status,
  output fre_pkg::fre_cmd_t   cmd
);

  fre_pkg::fre_state_t state_r;
  fre_pkg::fre_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fre_pkg::ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    if (restart) begin
      cmd.clr   = 1'b1;
      state_nxt = fre_pkg::ST_LOAD;
    end else if (start) begin
      unique case (state_r)
        fre_pkg::ST_LOAD: begin
          if (op == fre_pkg::OP_FETCH) begin
            cmd.err = 1'b1;
          end else begin
            cmd.wr = 1'b1;
            if (status.load_last) begin
              state_nxt = fre_pkg::ST_DRAIN;
            end
          end
        end
        fre_pkg::ST_DRAIN: begin
          // drop writes while a full frame waits
          if (op == fre_pkg::OP_FETCH) begin
            cmd.rd = 1'b1;
            if (status.frame_last) begin
              cmd.clr   = 1'b1;
              state_nxt = fre_pkg::ST_LOAD;
            end
          end
        end
        default: begin
          state_nxt = fre_pkg::ST_LOAD;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/fre_datapath.sv
// fre_datapath: load counter, rotated address generation, frame store and
// result register. Depends on fre_pkg and fre_store.
`default_nettype none

module fre_datapath #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  fre_pkg::fre_cmd_t     cmd,
  input  fre_pkg::size_t        frame_w,
  input  fre_pkg::size_t        frame_h,
  input  wire                   mode,
  input  fre_pkg::pix_t         wr_pixel,
  output fre_pkg::fre_status_t  status,
  output logic                  out_strobe,
  output fre_pkg::out_item_t    out_item
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int LCW   = $clog2(DEPTH + 1);
  localparam int AREA_W = 2 * fre_pkg::CFG_W;

  logic [LCW-1:0]      load_count_r;
  fre_pkg::size_t      row_r;
  fre_pkg::size_t      col_r;
  logic [AW-1:0]       col_base_r;
  logic [AW-1:0]       idx_r;
  logic                out_strobe_r;
  logic                err_r;
  logic                last_r;

  logic [AREA_W-1:0]   area;
  logic [LCW-1:0]      total;
  logic [LCW-1:0]      load_count_inc;
  fre_pkg::size_t      rows;
  fre_pkg::size_t      cols;
  logic                row_end;
  logic                col_end;
  logic [AW-1:0]       q_addr;
  logic [AW-1:0]       h_addr;
  logic [AW-1:0]       rd_addr;
  fre_pkg::pix_t       rdata;

  assign area           = AREA_W'(frame_w) * AREA_W'(frame_h);
  assign total          = LCW'(area);
  assign load_count_inc = load_count_r + LCW'(1);

  // quarter turn: output is width rows of height pixels
  assign rows    = (mode == fre_pkg::MODE_HALF) ? frame_h : frame_w;
  assign cols    = (mode == fre_pkg::MODE_HALF) ? frame_w : frame_h;
  assign row_end = (row_r == rows - 7'd1);
  assign col_end = (col_r == cols - 7'd1);

  assign status.load_last  = (load_count_inc == total);
  assign status.frame_last = row_end && col_end;

  // quarter turn reads col*w + (w-1-row); half turn walks the store backward
  assign q_addr  = col_base_r + AW'(frame_w - 7'd1 - row_r);
  assign h_addr  = AW'(total - LCW'(1)) - idx_r;
  assign rd_addr = (mode == fre_pkg::MODE_HALF) ? h_addr : q_addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_count_r <= '0;
      row_r        <= '0;
      col_r        <= '0;
      col_base_r   <= '0;
      idx_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.rd || cmd.err;
      if (cmd.clr) begin
        load_count_r <= '0;
        row_r        <= '0;
        col_r        <= '0;
        col_base_r   <= '0;
        idx_r        <= '0;
      end else if (cmd.wr) begin
        load_count_r <= load_count_inc;
      end else if (cmd.rd) begin
        idx_r <= idx_r + AW'(1);
        if (col_end) begin
          col_r      <= '0;
          row_r      <= row_r + 7'd1;
          col_base_r <= '0;
        end else begin
          col_r      <= col_r + 7'd1;
          col_base_r <= col_base_r + AW'(frame_w);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    err_r  <= cmd.err;
    last_r <= cmd.rd && status.frame_last;
  end

  fre_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (cmd.wr),
    .waddr (load_count_r[AW-1:0]),
    .wdata (wr_pixel),
    .re    (cmd.rd),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  assign out_strobe          = out_strobe_r;
  assign out_item.pixel_out  = err_r ? '0 : rdata;
  assign out_item.last_pixel = last_r;
  assign out_item.error      = err_r;

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// tb_top: self-checking bench for frame_rotation_engine (quarter and half turn).
// Depends on fre_pkg and the engine RTL; a queue-fed driver, a strobe monitor
// and a rotation predictor built into this module check every fetched pixel.

module tb_top;

  localparam int          MAX_W      = 64;
  localparam int          MAX_H      = 64;
  localparam int          STORE_SIZE = MAX_W * MAX_H;
  localparam int unsigned RAND_ITEMS = 650;
  localparam int unsigned DRAIN_WAIT = 200;
  // Slowest correct run: about 2500 items at the longest gap each plus settling is
  // under 5e5 time units; allow ten times that.
  localparam int unsigned LIMIT_TIME = 5_000_000;

  // Index with no register behind it; a write there must change nothing.
  localparam fre_pkg::cfg_idx_t CFG_UNUSED = 2'd3;

  typedef enum int {GAPS_NONE, GAPS_RANDOM, GAPS_SPARSE} gap_style_t;

  typedef struct {
    fre_pkg::in_item_t item;
    int unsigned       gap;
    bit                hold_for_drain;
  } pending_t;

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               start     = 1'b0;
  logic               busy;
  fre_pkg::in_item_t  in_item   = '0;
  logic               out_strobe;
  fre_pkg::out_item_t out_item;
  logic               cfg_we    = 1'b0;
  fre_pkg::cfg_idx_t  cfg_index = '0;
  fre_pkg::size_t     cfg_data  = '0;

  frame_rotation_engine #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Rotation predictor: its own copy of the registers, the frame store and
  // the fetch counters.
  // ---------------------------------------------------------------------------
  fre_pkg::size_t     width_reg;
  fre_pkg::size_t     height_reg;
  logic               mode_reg;
  fre_pkg::pix_t      frame_mem [0:STORE_SIZE-1];
  int unsigned        pixels_loaded;
  int unsigned        rot_row;
  int unsigned        rot_col;
  bit                 frame_full;

  fre_pkg::out_item_t rotated_q [$];   // fetched pixels still to come out
  int unsigned        n_expected;      // results predicted so far
  int unsigned        n_seen;          // results matched so far
  int unsigned        n_errors;

  // Zero acts as one, anything above the store's maximum acts as that maximum.
  function automatic int unsigned eff_size(input fre_pkg::size_t v, input int unsigned maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  function automatic void rearm_frame();
    pixels_loaded = 0;
    rot_row       = 0;
    rot_col       = 0;
    frame_full    = 1'b0;
  endfunction

  function automatic void set_frame_reg(input fre_pkg::cfg_idx_t idx, input fre_pkg::size_t val);
    bit hit;
    hit = 1'b1;
    case (idx)
      fre_pkg::CFG_FRAME_WIDTH:   width_reg  = val;
      fre_pkg::CFG_FRAME_HEIGHT:  height_reg = val;
      fre_pkg::CFG_ROTATION_MODE: mode_reg   = val[0];
      default:                    hit        = 1'b0;
    endcase
    // Only a defined register restarts the engine.
    if (hit) rearm_frame();
  endfunction

  function automatic void step_frame(input fre_pkg::in_item_t it);
    int unsigned        w, h, total, rows, cols, addr;
    fre_pkg::out_item_t res;
    bit                 last;
    w     = eff_size(width_reg, MAX_W);
    h     = eff_size(height_reg, MAX_H);
    total = w * h;
    if (it.op == fre_pkg::OP_WRITE) begin
      // Writes to a complete frame are dropped.
      if (!frame_full && pixels_loaded < total) begin
        frame_mem[pixels_loaded] = it.pixel;
        pixels_loaded++;
        if (pixels_loaded >= total) frame_full = 1'b1;
      end
      return;
    end
    n_expected++;
    if (!frame_full) begin
      // Fetch before the frame is complete: zero pixel, error flag, no change.
      res.pixel_out  = '0;
      res.last_pixel = 1'b0;
      res.error      = 1'b1;
      rotated_q.push_back(res);
      return;
    end
    if (mode_reg == fre_pkg::MODE_QUARTER) begin
      rows = w;
      cols = h;
      addr = rot_col * w + (w - 1 - rot_row);
    end else begin
      rows = h;
      cols = w;
      addr = (h - 1 - rot_row) * w + (w - 1 - rot_col);
    end
    last           = (rot_row + 1 >= rows) && (rot_col + 1 >= cols);
    res.pixel_out  = frame_mem[addr];
    res.last_pixel = last;
    res.error      = 1'b0;
    rotated_q.push_back(res);
    // The last pixel rearms the engine for the next frame.
    if (last) begin
      rearm_frame();
    end else if (rot_col + 1 >= cols) begin
      rot_col = 0;
      rot_row++;
    end else begin
      rot_col++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: take items from the pending queue, wait out each item's gap, hold
  // an item until accepted, and feed every accepted item to the predictor.
  // ---------------------------------------------------------------------------
  pending_t    pend_q [$];
  pending_t    cur;
  bit          staged;
  bit          accepted;
  int unsigned gap_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      start      <= 1'b0;
      staged     = 1'b0;
      gap_left   = 0;
      width_reg  = 7'd64;
      height_reg = 7'd64;
      mode_reg   = fre_pkg::MODE_QUARTER;
      rearm_frame();
    end else begin
      accepted = start && !busy;
      if (cfg_we) set_frame_reg(cfg_index, cfg_data);
      if (accepted) step_frame(in_item);
      if (start && !accepted) begin
        // hold the item until the engine takes it
      end else begin
        if (!staged && pend_q.size() != 0) begin
          cur      = pend_q.pop_front();
          staged   = 1'b1;
          gap_left = cur.gap;
        end
        if (!staged) begin
          start <= 1'b0;
        end else if (gap_left != 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (cur.hold_for_drain && (accepted || n_expected != n_seen)) begin
          // pause until every predicted result has come out
          start <= 1'b0;
        end else begin
          start   <= 1'b1;
          in_item <= cur.item;
          staged  = 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every strobed result is checked against the oldest prediction.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    n_errors++;
  endtask

  always @(posedge clk) begin : watch_results
    fre_pkg::out_item_t want;
    if (rst_n && out_strobe !== 1'b0) begin
      if (rotated_q.size() == 0) begin
        report_mismatch($sformatf("result %h with no fetch pending", out_item));
      end else begin
        want = rotated_q.pop_front();
        if (out_item.pixel_out !== want.pixel_out)
          report_mismatch($sformatf("pixel_out %h, want %h", out_item.pixel_out,
                                    want.pixel_out));
        if (out_item.last_pixel !== want.last_pixel)
          report_mismatch($sformatf("last_pixel %b, want %b", out_item.last_pixel,
                                    want.last_pixel));
        if (out_item.error !== want.error)
          report_mismatch($sformatf("error %b, want %b", out_item.error, want.error));
        n_seen <= n_seen + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  gap_style_t  gap_style;
  int unsigned n_pushed;

  function automatic int unsigned draw_gap();
    case (gap_style)
      GAPS_NONE:   return 0;
      GAPS_RANDOM: return $urandom_range(0, 17);
      default:     return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 17) : 0;
    endcase
  endfunction

  function automatic void push_item(input logic op, input fre_pkg::pix_t pix,
                                    input bit hold_for_drain);
    pending_t p;
    p.item.op        = op;
    p.item.pixel     = pix;
    p.gap            = draw_gap();
    p.hold_for_drain = hold_for_drain;
    pend_q.push_back(p);
    n_pushed++;
  endfunction

  function automatic fre_pkg::pix_t rand_pixel();
    return fre_pkg::pix_t'($urandom());
  endfunction

  // Mostly small sizes; sometimes zero, the maximum range, or above it.
  function automatic int unsigned draw_size();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return $urandom_range(65, 127);
      2:       return $urandom_range(9, 64);
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  // Wait until the driver has nothing left and every result is back, then
  // let the engine's registered result pass with margin.
  task automatic settle();
    while (pend_q.size() != 0 || staged || start || n_expected != n_seen)
      @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_reg(input fre_pkg::cfg_idx_t idx, input int unsigned val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= fre_pkg::size_t'(val);
  endtask

  task automatic end_cfg();
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_frame(input int unsigned total);
    for (int unsigned i = 0; i < total; i++)
      push_item(fre_pkg::OP_WRITE, rand_pixel(), 1'b0);
  endtask

  initial begin : stimulus
    int unsigned w_val, h_val, tmp, total, cut, kind, rand_goal;
    bit          drain;

    n_expected = 0;
    n_seen     = 0;
    n_errors   = 0;
    n_pushed   = 0;
    gap_style  = GAPS_RANDOM;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: fetch with no frame loaded after reset.
    push_item(fre_pkg::OP_FETCH, 24'h123456, 1'b0);
    settle();

    // Width zero acts as one: a 1x3 frame, one extra write dropped, the
    // whole frame fetched, then one fetch past the end.
    set_reg(fre_pkg::CFG_FRAME_WIDTH, 0);
    set_reg(fre_pkg::CFG_FRAME_HEIGHT, 3);
    set_reg(fre_pkg::CFG_ROTATION_MODE, fre_pkg::MODE_QUARTER);
    end_cfg();
    push_item(fre_pkg::OP_WRITE, 24'h000000, 1'b0);
    push_item(fre_pkg::OP_WRITE, 24'hFFFFFF, 1'b0);
    push_item(fre_pkg::OP_WRITE, 24'hA5A5A5, 1'b0);
    push_item(fre_pkg::OP_WRITE, 24'h5A5A5A, 1'b0);
    push_item(fre_pkg::OP_FETCH, 24'hFFFFFF, 1'b0);
    push_item(fre_pkg::OP_FETCH, 24'h000000, 1'b1);
    push_item(fre_pkg::OP_FETCH, 24'h800001, 1'b0);
    push_item(fre_pkg::OP_FETCH, 24'h7FFFFE, 1'b0);
    settle();

    // Half turn of a 2x2 frame; a fetch mid-load errors, and a write to the
    // unused index must not restart the load.
    set_reg(fre_pkg::CFG_FRAME_WIDTH, 2);
    set_reg(fre_pkg::CFG_FRAME_HEIGHT, 2);
    set_reg(fre_pkg::CFG_ROTATION_MODE, fre_pkg::MODE_HALF);
    end_cfg();
    push_item(fre_pkg::OP_WRITE, 24'h010203, 1'b0);
    push_item(fre_pkg::OP_WRITE, 24'hFEDCBA, 1'b0);
    push_item(fre_pkg::OP_FETCH, 24'h000000, 1'b0);
    settle();
    set_reg(CFG_UNUSED, 7'h7F);
    end_cfg();
    push_item(fre_pkg::OP_WRITE, 24'hC0FFEE, 1'b0);
    push_item(fre_pkg::OP_WRITE, 24'h0F0F0F, 1'b0);
    repeat (4) push_item(fre_pkg::OP_FETCH, rand_pixel(), 1'b0);
    settle();

    // Tall frame: width 6, height above the maximum (acts as 64). Load it
    // whole, fetch part of it, then leave it for the next write to restart.
    gap_style = GAPS_NONE;
    set_reg(fre_pkg::CFG_FRAME_WIDTH, 6);
    set_reg(fre_pkg::CFG_FRAME_HEIGHT, 127);
    set_reg(fre_pkg::CFG_ROTATION_MODE, $urandom_range(0, 1));
    end_cfg();
    load_frame(6 * MAX_H);
    repeat (100) push_item(fre_pkg::OP_FETCH, rand_pixel(), 1'b0);

    // Random phases: mostly well-formed frames with random content, some
    // drained part way, some plain noise.
    rand_goal = n_pushed + RAND_ITEMS;
    while (n_pushed < rand_goal) begin
      settle();
      w_val = draw_size();
      h_val = (eff_size(fre_pkg::size_t'(w_val), MAX_W) > 8) ? $urandom_range(0, 4) :
                                                               draw_size();
      if ($urandom_range(0, 1) != 0) begin
        tmp   = w_val;
        w_val = h_val;
        h_val = tmp;
      end
      set_reg(fre_pkg::CFG_FRAME_WIDTH, w_val);
      set_reg(fre_pkg::CFG_FRAME_HEIGHT, h_val);
      set_reg(fre_pkg::CFG_ROTATION_MODE, $urandom_range(0, 1));
      if ($urandom_range(0, 15) == 0) set_reg(CFG_UNUSED, $urandom_range(0, 127));
      end_cfg();
      total     = eff_size(fre_pkg::size_t'(w_val), MAX_W) *
                  eff_size(fre_pkg::size_t'(h_val), MAX_H);
      gap_style = gap_style_t'($urandom_range(0, 2));
      kind      = $urandom_range(0, 9);
      if (kind <= 6) begin
        repeat ($urandom_range(1, 2)) begin
          for (int unsigned i = 0; i < total; i++) begin
            if ($urandom_range(0, 19) == 0) push_item(fre_pkg::OP_FETCH, rand_pixel(), 1'b0);
            push_item(fre_pkg::OP_WRITE, rand_pixel(), 1'b0);
          end
          // writes past the full frame are dropped
          repeat ($urandom_range(0, 2)) push_item(fre_pkg::OP_WRITE, rand_pixel(), 1'b0);
          for (int unsigned i = 0; i < total; i++) begin
            drain = (i != 0) && ($urandom_range(0, 15) == 0);
            push_item(fre_pkg::OP_FETCH, rand_pixel(), drain);
          end
          if ($urandom_range(0, 3) == 0) push_item(fre_pkg::OP_FETCH, rand_pixel(), 1'b0);
        end
      end else if (kind <= 8) begin
        // stop mid-drain; the next register write restarts the engine
        load_frame(total);
        cut = $urandom_range(0, total - 1);
        repeat (cut) push_item(fre_pkg::OP_FETCH, rand_pixel(), 1'b0);
      end else begin
        repeat ($urandom_range(5, 30))
          push_item(($urandom_range(0, 1) != 0) ? fre_pkg::OP_FETCH : fre_pkg::OP_WRITE,
                    rand_pixel(), 1'b0);
      end
    end

    // Drain: wait for the last items and results, bounded.
    while (pend_q.size() != 0 || staged || start) @(negedge clk);
    for (int unsigned i = 0; i < DRAIN_WAIT && n_expected != n_seen; i++) @(negedge clk);
    repeat (5) @(negedge clk);
    if (rotated_q.size() != 0)
      report_mismatch($sformatf("%0d predicted results never came out", rotated_q.size()));

    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: end a hung run.
  initial begin
    #(LIMIT_TIME);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
